### hdl/assert_macros.svh
// assertion macros for the matrix stack
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

### hdl/fpms_pkg.sv
// shared types, codes and helpers of the matrix stack
`timescale 1ns / 1ps
package fpms_pkg;
   localparam int MODELVIEW_DEPTH_DEF  = 16;
   localparam int PROJECTION_DEPTH_DEF = 2;
   localparam logic [31:0] FIX_ONE = 32'h0001_0000;

   typedef enum logic [3:0] {
      FUNC_WRITE  = 4'd0,
      FUNC_LOAD   = 4'd1,
      FUNC_IDENT  = 4'd2,
      FUNC_PUSH   = 4'd3,
      FUNC_POP    = 4'd4,
      FUNC_MUL    = 4'd5,
      FUNC_SCALE  = 4'd6,
      FUNC_TRANS  = 4'd7,
      FUNC_XFORM4 = 4'd8,
      FUNC_XFORM3 = 4'd9
   } func_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic [3:0] idx;
   } mac_tag_type;

   function automatic logic [31:0] ident_elem(input logic [3:0] e);
      ident_elem = (e[1:0] == e[3:2]) ? FIX_ONE : 32'd0;
   endfunction
endpackage

### hdl/fpms_store.sv
// stack memory holding both matrix stacks, row zero of each reads identity until its last element is written
`timescale 1ns / 1ps
module fpms_store #(
   parameter int MODELVIEW_DEPTH  = fpms_pkg::MODELVIEW_DEPTH_DEF,
   parameter int PROJECTION_DEPTH = fpms_pkg::PROJECTION_DEPTH_DEF,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data
);
   import fpms_pkg::*;
   localparam int ROW_W = ADDR_W - 4;
   localparam int WORDS = (MODELVIEW_DEPTH + PROJECTION_DEPTH) * 16;
   localparam logic [ROW_W-1:0] PJ_ROW0 = ROW_W'(MODELVIEW_DEPTH);

   logic [31:0] mem [WORDS];
   logic [31:0] q_ff;
   logic        id_ff;
   logic [3:0]  e_ff;
   logic        mv_done_ff, pj_done_ff;
   logic [ROW_W-1:0] rd_row, wr_row;

   assign rd_row = rd_addr[ADDR_W-1:4];
   assign wr_row = wr_addr[ADDR_W-1:4];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff  <= mem[rd_addr];
         e_ff  <= rd_addr[3:0];
         id_ff <= (rd_row == '0 && !mv_done_ff) || (rd_row == PJ_ROW0 && !pj_done_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_done_ff <= 1'b0;
         pj_done_ff <= 1'b0;
      end else if (wr_en && wr_addr[3:0] == 4'd15) begin
         if (wr_row == '0) mv_done_ff <= 1'b1;
         if (wr_row == PJ_ROW0) pj_done_ff <= 1'b1;
      end
   end

   assign rd_data = id_ff ? ident_elem(e_ff) : q_ff;
endmodule

### hdl/fpms_opmem.sv
// operand matrix memory
`timescale 1ns / 1ps
module fpms_opmem (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [31:0] wr_data,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);
   logic [31:0] mem [16];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### hdl/fpms_mac.sv
// pipelined 16.16 multiply-accumulate unit
`timescale 1ns / 1ps
module fpms_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  fpms_pkg::mac_tag_type issue_tag,
   input  logic signed [31:0]    issue_a,
   input  logic signed [31:0]    issue_b,
   input  logic                  issue_use_mem,
   input  logic signed [31:0]    mem_data,
   output logic                  res_valid,
   output logic [3:0]            res_idx,
   output logic [31:0]           res_data,
   output logic                  busy
);
   import fpms_pkg::*;
   mac_tag_type        tag1_ff, tag2_ff;
   logic signed [31:0] a1_ff, b1_ff, b2;
   logic               use1_ff;
   logic signed [63:0] prod;
   logic [31:0]        prod_ff, acc_ff, acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= issue_tag;
         tag2_ff <= tag1_ff;
      end
   end

   assign b2   = use1_ff ? mem_data : b1_ff;
   assign prod = a1_ff * b2;

   always_ff @(posedge clock) begin
      a1_ff   <= issue_a;
      b1_ff   <= issue_b;
      use1_ff <= issue_use_mem;
      prod_ff <= prod[47:16];
      if (tag2_ff.valid) acc_ff <= acc_in;
   end

   assign acc_in    = (tag2_ff.first ? 32'd0 : acc_ff) + prod_ff;
   assign res_valid = tag2_ff.valid && tag2_ff.last;
   assign res_idx   = tag2_ff.idx;
   assign res_data  = acc_in;
   assign busy      = tag1_ff.valid || tag2_ff.valid;
endmodule

### hdl/fixed_point_matrix_stack.sv
// top level of the fixed-point matrix stack
// One request beat carries one operation on the top matrix of the selected stack
// (modelview or projection): operand write, load, identity, push, pop, multiply,
// scale, translate, or a 4- or 3-vector transform. Each request beat yields one
// response beat with the transformed vector (zero for other operations) and a
// status of ok, overflow or underflow.
// Requests are taken one at a time; req_ready is high only while the sequencer
// is idle. Load, identity and push copy a matrix into the matrix memory; the
// other arithmetic operations fetch the top matrix and run on the one
// multiply-accumulate unit, multiply and translate as 64 accumulate steps.
// The result sits in an output register; a new request is taken while it waits,
// and a following result holds in the sequencer until rsp_ready frees the register.
// Synchronous reset empties both stacks and makes both bottom matrices identity.
`timescale 1ns / 1ps
module fixed_point_matrix_stack #(
   parameter int MODELVIEW_DEPTH  = fpms_pkg::MODELVIEW_DEPTH_DEF,
   parameter int PROJECTION_DEPTH = fpms_pkg::PROJECTION_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_func,
   input  logic               req_stack_sel,
   input  logic [3:0]         req_elem_index,
   input  logic signed [31:0] req_elem_value,
   input  logic signed [31:0] req_vx,
   input  logic signed [31:0] req_vy,
   input  logic signed [31:0] req_vz,
   input  logic signed [31:0] req_vw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic signed [31:0] rsp_out_w,
   output logic [1:0]         rsp_status
);
   import fpms_pkg::*;
`include "assert_macros.svh"

   localparam int MVT_W  = $clog2(MODELVIEW_DEPTH);
   localparam int PJT_W  = $clog2(PROJECTION_DEPTH);
   localparam int ROW_W  = $clog2(MODELVIEW_DEPTH + PROJECTION_DEPTH);
   localparam int ADDR_W = ROW_W + 4;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_COPY  = 6'b000010,
      S_FETCH = 6'b000100,
      S_MAC   = 6'b001000,
      S_DRAIN = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type        state_ff;
   logic [3:0]       func_ff;
   logic             sel_ff;
   logic [31:0]      v_ff [4];
   logic [31:0]      rx_ff [4];
   logic [1:0]       status_ff;
   logic [MVT_W-1:0] mv_top_ff;
   logic [PJT_W-1:0] pj_top_ff;
   logic [4:0]       cnt_ff;
   logic             cp_valid_ff;
   logic [3:0]       cp_idx_ff;
   logic [31:0]      tm_ff [16];
   logic [3:0]       o_ff;
   logic [1:0]       k_ff;
   logic             rsp_valid_ff;
   logic [31:0]      rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_w_ff;
   logic [1:0]       rsp_st_ff;

   logic             accept, mv_full, pj_full, is_xform, is_matmul;
   logic [ROW_W-1:0] row_src, row_dst;
   logic             st_rd_en, st_wr_en;
   logic [ADDR_W-1:0] st_rd_addr, st_wr_addr;
   logic [31:0]      st_rd_data, st_wr_data, op_rd_data;
   logic [3:0]       op_rd_addr;
   logic [1:0]       nterm_m1;
   logic [3:0]       nout_m1, a_idx;
   logic             step_last, out_last;
   mac_tag_type      issue_tag;
   logic [31:0]      issue_a, issue_b;
   logic             res_valid, mac_busy;
   logic [3:0]       res_idx;
   logic [31:0]      res_data;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign mv_full   = ({1'b0, mv_top_ff} + 1'b1) >= (MVT_W + 1)'(MODELVIEW_DEPTH);
   assign pj_full   = ({1'b0, pj_top_ff} + 1'b1) >= (PJT_W + 1)'(PROJECTION_DEPTH);
   assign is_xform  = (func_ff == FUNC_XFORM4) || (func_ff == FUNC_XFORM3);
   assign is_matmul = (func_ff == FUNC_MUL);
   assign row_src   = sel_ff ? ROW_W'(MODELVIEW_DEPTH) + ROW_W'(pj_top_ff)
                             : ROW_W'(mv_top_ff);
   assign row_dst   = (func_ff == FUNC_PUSH) ? row_src + 1'b1 : row_src;

   // term and output counts per operation
   always_comb begin
      case (func_ff)
         FUNC_SCALE:  begin nterm_m1 = 2'd0; nout_m1 = 4'd15; end
         FUNC_XFORM4: begin nterm_m1 = 2'd3; nout_m1 = 4'd3;  end
         FUNC_XFORM3: begin nterm_m1 = 2'd2; nout_m1 = 4'd2;  end
         default:     begin nterm_m1 = 2'd3; nout_m1 = 4'd15; end
      endcase
   end
   assign step_last = (k_ff == nterm_m1);
   assign out_last  = step_last && (o_ff == nout_m1);

   // operands of one accumulate step
   always_comb begin
      case (func_ff)
         FUNC_SCALE: begin
            a_idx   = o_ff;
            issue_b = (o_ff[3:2] == 2'd3) ? FIX_ONE : v_ff[o_ff[3:2]];
         end
         FUNC_XFORM4, FUNC_XFORM3: begin
            a_idx   = {k_ff, o_ff[1:0]};
            issue_b = v_ff[k_ff];
         end
         FUNC_TRANS: begin
            a_idx   = {k_ff, o_ff[1:0]};
            if (o_ff[3:2] == 2'd3 && k_ff != 2'd3) issue_b = v_ff[k_ff];
            else if (o_ff[3:2] == k_ff) issue_b = FIX_ONE;
            else issue_b = 32'd0;
         end
         default: begin
            a_idx   = {k_ff, o_ff[1:0]};
            issue_b = 32'd0;
         end
      endcase
   end
   assign issue_a         = tm_ff[a_idx];
   assign issue_tag.valid = (state_ff == S_MAC);
   assign issue_tag.first = (k_ff == 2'd0);
   assign issue_tag.last  = step_last;
   assign issue_tag.idx   = o_ff;

   assign op_rd_addr = (state_ff == S_MAC) ? {o_ff[3:2], k_ff} : cnt_ff[3:0];
   assign st_rd_en   = (state_ff == S_COPY || state_ff == S_FETCH) && !cnt_ff[4];
   assign st_rd_addr = {row_src, cnt_ff[3:0]};

   always_comb begin
      st_wr_en   = 1'b0;
      st_wr_addr = {row_dst, cp_idx_ff};
      st_wr_data = st_rd_data;
      if (state_ff == S_COPY) begin
         st_wr_en = cp_valid_ff;
         case (func_ff)
            FUNC_LOAD:  st_wr_data = op_rd_data;
            FUNC_IDENT: st_wr_data = ident_elem(cp_idx_ff);
            default:    st_wr_data = st_rd_data;
         endcase
      end else if (res_valid && !is_xform) begin
         st_wr_en   = 1'b1;
         st_wr_addr = {row_src, res_idx};
         st_wr_data = res_data;
      end
   end

   fpms_store #(
      .MODELVIEW_DEPTH (MODELVIEW_DEPTH),
      .PROJECTION_DEPTH(PROJECTION_DEPTH),
      .ADDR_W          (ADDR_W)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (st_rd_en),
      .rd_addr(st_rd_addr),
      .rd_data(st_rd_data),
      .wr_en  (st_wr_en),
      .wr_addr(st_wr_addr),
      .wr_data(st_wr_data)
   );

   fpms_opmem u_opmem (
      .clock  (clock),
      .wr_en  (accept && req_func == FUNC_WRITE),
      .wr_addr(req_elem_index),
      .wr_data(req_elem_value),
      .rd_addr(op_rd_addr),
      .rd_data(op_rd_data)
   );

   fpms_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .issue_tag    (issue_tag),
      .issue_a      (issue_a),
      .issue_b      (issue_b),
      .issue_use_mem(is_matmul),
      .mem_data     (op_rd_data),
      .res_valid    (res_valid),
      .res_idx      (res_idx),
      .res_data     (res_data),
      .busy         (mac_busy)
   );

   // payload and datapath registers
   always_ff @(posedge clock) begin
      cp_idx_ff <= cnt_ff[3:0];
      if (accept) begin
         func_ff <= req_func;
         sel_ff  <= req_stack_sel;
         v_ff[0] <= req_vx;
         v_ff[1] <= req_vy;
         v_ff[2] <= req_vz;
         v_ff[3] <= req_vw;
         for (int i = 0; i < 4; i++) rx_ff[i] <= 32'd0;
      end else if (res_valid && is_xform) begin
         rx_ff[res_idx[1:0]] <= res_data;
      end
      if (state_ff == S_FETCH && cp_valid_ff) tm_ff[cp_idx_ff] <= st_rd_data;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         mv_top_ff   <= '0;
         pj_top_ff   <= '0;
         cnt_ff      <= '0;
         cp_valid_ff <= 1'b0;
         o_ff        <= '0;
         k_ff        <= '0;
         status_ff   <= STATUS_OK;
      end else begin
         cp_valid_ff <= st_rd_en || (state_ff == S_COPY && !cnt_ff[4]);
         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               o_ff   <= '0;
               k_ff   <= '0;
               if (accept) begin
                  case (req_func)
                     FUNC_LOAD, FUNC_IDENT: begin
                        status_ff <= STATUS_OK;
                        state_ff  <= S_COPY;
                     end
                     FUNC_PUSH: begin
                        if (req_stack_sel ? pj_full : mv_full) begin
                           status_ff <= STATUS_OVERFLOW;
                           state_ff  <= S_RESP;
                        end else begin
                           status_ff <= STATUS_OK;
                           state_ff  <= S_COPY;
                        end
                     end
                     FUNC_POP: begin
                        state_ff <= S_RESP;
                        if (req_stack_sel) begin
                           if (pj_top_ff == '0) begin
                              status_ff <= STATUS_UNDERFLOW;
                           end else begin
                              status_ff <= STATUS_OK;
                              pj_top_ff <= pj_top_ff - 1'b1;
                           end
                        end else begin
                           if (mv_top_ff == '0) begin
                              status_ff <= STATUS_UNDERFLOW;
                           end else begin
                              status_ff <= STATUS_OK;
                              mv_top_ff <= mv_top_ff - 1'b1;
                           end
                        end
                     end
                     FUNC_MUL, FUNC_SCALE, FUNC_TRANS, FUNC_XFORM4, FUNC_XFORM3: begin
                        status_ff <= STATUS_OK;
                        state_ff  <= S_FETCH;
                     end
                     default: begin
                        status_ff <= STATUS_OK;
                        state_ff  <= S_RESP;
                     end
                  endcase
               end
            end
            S_COPY: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff[4]) begin
                  state_ff <= S_RESP;
                  if (func_ff == FUNC_PUSH) begin
                     if (sel_ff) pj_top_ff <= pj_top_ff + 1'b1;
                     else mv_top_ff <= mv_top_ff + 1'b1;
                  end
               end
            end
            S_FETCH: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff[4]) state_ff <= S_MAC;
            end
            S_MAC: begin
               if (step_last) begin
                  k_ff <= '0;
                  o_ff <= o_ff + 1'b1;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
               if (out_last) state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               if (!mac_busy) state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_RESP && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RESP && (!rsp_valid_ff || rsp_ready)) begin
         rsp_x_ff  <= rx_ff[0];
         rsp_y_ff  <= rx_ff[1];
         rsp_z_ff  <= rx_ff[2];
         rsp_w_ff  <= rx_ff[3];
         rsp_st_ff <= status_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = rsp_x_ff;
   assign rsp_out_y  = rsp_y_ff;
   assign rsp_out_z  = rsp_z_ff;
   assign rsp_out_w  = rsp_w_ff;
   assign rsp_status = rsp_st_ff;

   `ASSERT_IMPL(a_mac_in_compute, clock, reset, mac_busy, state_ff == S_MAC || state_ff == S_DRAIN)
   `ASSERT_IMPL(a_tops_in_range, clock, reset, 1'b1, 32'(mv_top_ff) < MODELVIEW_DEPTH && 32'(pj_top_ff) < PROJECTION_DEPTH)
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, accept, !req_ready)
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))
endmodule

### tb/testbench.sv
// self-checking testbench of the fixed-point matrix stack
`timescale 1ns / 1ps
module testbench;
   import fpms_pkg::*;

   localparam int MV_DEPTH      = MODELVIEW_DEPTH_DEF;
   localparam int PJ_DEPTH      = PROJECTION_DEPTH_DEF;
   localparam logic [3:0] FUNC_UNUSED = 4'd15;
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 300;
   localparam int TAIL_CYCLES   = 200;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
      logic [1:0]  status;
   } vec_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [3:0]         req_func;
   logic               req_stack_sel;
   logic [3:0]         req_elem_index;
   logic signed [31:0] req_elem_value;
   logic signed [31:0] req_vx;
   logic signed [31:0] req_vy;
   logic signed [31:0] req_vz;
   logic signed [31:0] req_vw;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic signed [31:0] rsp_out_w;
   logic [1:0]         rsp_status;

   // predictor state
   logic [31:0] mv_mat [MV_DEPTH][16];
   logic [31:0] pj_mat [PJ_DEPTH][16];
   int          mv_top;
   int          pj_top;
   logic [31:0] operand [16];

   vec_result_type expected_vecs[$];
   int  error_count;
   int  quiet_cycles;
   bit  idle_on;
   int  hold_left;
   int  rsp_stall_left;

   fixed_point_matrix_stack i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_stack_sel  (req_stack_sel),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .req_vx         (req_vx),
      .req_vy         (req_vy),
      .req_vz         (req_vz),
      .req_vw         (req_vw),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_out_w      (rsp_out_w),
      .rsp_status     (rsp_status)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [31:0] fix_mul(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] p;
      p = $signed(a) * $signed(b);
      return p[47:16];
   endfunction

   function automatic void mat_mult(ref logic [31:0] dst [16], input logic [31:0] rhs [16]);
      logic [31:0] prod [16];
      logic [31:0] acc;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            acc = 32'd0;
            for (int k = 0; k < 4; k++) acc += fix_mul(dst[4*k+r], rhs[4*c+k]);
            prod[4*c+r] = acc;
         end
      end
      dst = prod;
   endfunction

   function automatic vec_result_type predict_vec(input logic [3:0] func, input logic sel,
         input logic [3:0] idx, input logic [31:0] val, input logic [31:0] v [4]);
      vec_result_type res;
      logic [31:0] top [16];
      logic [31:0] tmp [16];
      logic [31:0] outv [4];
      logic [31:0] acc;
      int n;
      res = '{32'd0, 32'd0, 32'd0, 32'd0, STATUS_OK};
      outv = '{32'd0, 32'd0, 32'd0, 32'd0};
      top = sel ? pj_mat[pj_top] : mv_mat[mv_top];
      case (func)
         FUNC_WRITE: operand[idx] = val;
         FUNC_LOAD: top = operand;
         FUNC_IDENT: for (int i = 0; i < 16; i++) top[i] = (i % 5 == 0) ? FIX_ONE : 32'd0;
         FUNC_PUSH: begin
            if (sel) begin
               if (pj_top + 1 >= PJ_DEPTH) res.status = STATUS_OVERFLOW;
               else begin
                  pj_top++;
                  pj_mat[pj_top] = top;
               end
            end else begin
               if (mv_top + 1 >= MV_DEPTH) res.status = STATUS_OVERFLOW;
               else begin
                  mv_top++;
                  mv_mat[mv_top] = top;
               end
            end
            return res;
         end
         FUNC_POP: begin
            if (sel) begin
               if (pj_top == 0) res.status = STATUS_UNDERFLOW;
               else pj_top--;
            end else begin
               if (mv_top == 0) res.status = STATUS_UNDERFLOW;
               else mv_top--;
            end
            return res;
         end
         FUNC_MUL: mat_mult(top, operand);
         FUNC_SCALE: begin
            for (int j = 0; j < 3; j++)
               for (int i = 0; i < 4; i++) top[4*j+i] = fix_mul(top[4*j+i], v[j]);
         end
         FUNC_TRANS: begin
            for (int i = 0; i < 16; i++) tmp[i] = (i % 5 == 0) ? FIX_ONE : 32'd0;
            tmp[12] = v[0];
            tmp[13] = v[1];
            tmp[14] = v[2];
            mat_mult(top, tmp);
         end
         FUNC_XFORM4, FUNC_XFORM3: begin
            n = (func == FUNC_XFORM4) ? 4 : 3;
            for (int i = 0; i < n; i++) begin
               acc = 32'd0;
               for (int j = 0; j < n; j++) acc += fix_mul(top[i+4*j], v[j]);
               outv[i] = acc;
            end
            res.x = outv[0];
            res.y = outv[1];
            res.z = outv[2];
            res.w = outv[3];
         end
         default: ;
      endcase
      if (sel) pj_mat[pj_top] = top;
      else mv_mat[mv_top] = top;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   // one request beat, predicted when accepted
   task automatic send_request(input logic [3:0] func, input logic sel, input logic [3:0] idx,
         input logic [31:0] val, input logic [31:0] x, input logic [31:0] y,
         input logic [31:0] z, input logic [31:0] w);
      logic [31:0] v [4];
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_func       = func;
      req_stack_sel  = sel;
      req_elem_index = idx;
      req_elem_value = val;
      req_vx         = x;
      req_vy         = y;
      req_vz         = z;
      req_vw         = w;
      do @(posedge clock); while (!req_ready);
      v = '{x, y, z, w};
      expected_vecs.push_back(predict_vec(func, sel, idx, val, v));
      @(negedge clock);
   endtask

   task automatic release_request();
      req_valid = 1'b0;
   endtask

   function automatic logic [31:0] rand_fix();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return FIX_ONE;
         default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      endcase
   endfunction

   task automatic send_random_op();
      logic [3:0] func;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) func = FUNC_WRITE;
      else if (pick < 25) func = FUNC_LOAD;
      else if (pick < 32) func = FUNC_IDENT;
      else if (pick < 44) func = FUNC_PUSH;
      else if (pick < 56) func = FUNC_POP;
      else if (pick < 60) func = FUNC_MUL;
      else if (pick < 66) func = FUNC_SCALE;
      else if (pick < 71) func = FUNC_TRANS;
      else if (pick < 84) func = FUNC_XFORM4;
      else if (pick < 96) func = FUNC_XFORM3;
      else func = $urandom_range(10, 15);
      send_request(func, $urandom_range(0, 1), $urandom_range(0, 15), rand_fix(),
         rand_fix(), rand_fix(), rand_fix(), rand_fix());
   endtask

   task automatic test_operand_write();
      logic [31:0] vals [4];
      vals = '{32'h8000_0000, 32'h7fff_ffff, FIX_ONE, 32'hffff_ffff};
      for (int i = 0; i < 16; i++)
         send_request(FUNC_WRITE, i[0], i[3:0], (i % 5 == 0) ? vals[i/5] : $urandom(),
            32'd0, 32'd0, 32'd0, 32'd0);
   endtask

   task automatic test_stack_ops();
      send_request(FUNC_POP, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_request(FUNC_PUSH, 1'b1, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_request(FUNC_PUSH, 1'b1, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_request(FUNC_LOAD, 1'b1, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_request(FUNC_XFORM4, 1'b1, 4'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000,
         FIX_ONE, 32'hffff_ffff);
      send_request(FUNC_POP, 1'b1, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_request(FUNC_IDENT, 1'b1, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_request(FUNC_UNUSED, 1'b0, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
         32'hffff_ffff, 32'hffff_ffff);
   endtask

   task automatic test_arithmetic();
      send_request(FUNC_MUL, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_request(FUNC_SCALE, 1'b0, 4'd0, 32'd0, 32'h0002_0000, 32'hffff_8000,
         32'h8000_0000, 32'd0);
      send_request(FUNC_TRANS, 1'b0, 4'd0, 32'd0, 32'h7fff_ffff, 32'h0001_8000,
         32'hfffe_0000, 32'd0);
      send_request(FUNC_XFORM3, 1'b0, 4'd0, 32'd0, FIX_ONE, 32'h8000_0000,
         32'h7fff_ffff, 32'h1234_5678);
   endtask

   // walks the modelview stack up to overflow and back down to underflow
   task automatic test_stack_extremes();
      for (int i = 0; i < MV_DEPTH + 1; i++)
         send_request(FUNC_PUSH, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      for (int i = 0; i < MV_DEPTH + 1; i++)
         send_request(FUNC_POP, 1'b0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_random_op();
   endtask

   task automatic test_backpressure();
      hold_left = HOLD_CYCLES;
      test_random(20);
   endtask

   task automatic test_drain_pause();
      release_request();
      wait (expected_vecs.size() == 0);
      @(negedge clock);
      test_random(20);
   endtask

   // response side with random bursts of stall and one long hold-off
   initial begin
      rsp_ready = 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (rsp_stall_left > 0) begin
            rsp_ready = 1'b0;
            rsp_stall_left--;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            rsp_stall_left = $urandom_range(0, 2);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      vec_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_vecs.size() == 0) begin
            report_mismatch("unexpected beat", rsp_out_x, 32'd0);
         end else begin
            want = expected_vecs.pop_front();
            if (rsp_out_x !== want.x) report_mismatch("out_x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y) report_mismatch("out_y", rsp_out_y, want.y);
            if (rsp_out_z !== want.z) report_mismatch("out_z", rsp_out_z, want.z);
            if (rsp_out_w !== want.w) report_mismatch("out_w", rsp_out_w, want.w);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      error_count = 0;
      quiet_cycles = 0;
      hold_left = 0;
      idle_on = 1'b1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_WRITE;
      req_stack_sel = 1'b0;
      req_elem_index = 4'd0;
      req_elem_value = 32'd0;
      req_vx = 32'd0;
      req_vy = 32'd0;
      req_vz = 32'd0;
      req_vw = 32'd0;
      for (int s = 0; s < MV_DEPTH; s++)
         for (int i = 0; i < 16; i++) mv_mat[s][i] = (i % 5 == 0) ? FIX_ONE : 32'd0;
      for (int s = 0; s < PJ_DEPTH; s++)
         for (int i = 0; i < 16; i++) pj_mat[s][i] = (i % 5 == 0) ? FIX_ONE : 32'd0;
      for (int i = 0; i < 16; i++) operand[i] = 32'd0;
      mv_top = 0;
      pj_top = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_operand_write();
      test_stack_ops();
      test_arithmetic();
      test_stack_extremes();
      test_random(500);
      test_backpressure();
      test_drain_pause();
      test_random(500);
      idle_on = 1'b0;
      test_random(200);
      release_request();
      wait (expected_vecs.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
